// ----- rtl/mmpx_pkg.sv -----
// ============================================================================
// mmpx_pkg
// Shared types and constants for the multiset minimum pair xor block:
// transaction payloads, action and status codes, cell control and link types.
// ============================================================================
package mmpx_pkg;

    localparam int VALUE_W      = 30;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 9;
    localparam int DEF_CAPACITY = 256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_FEW    = 2'd3
    } status_t;

    // input transaction
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } cmd_item_t;

    // output transaction
    typedef struct packed {
        logic [VALUE_W-1:0]  min_xor;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } res_item_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

    // broadcast from controller to every cell
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic               valid;
        logic               gt;
        logic [VALUE_W-1:0] value;
    } cell_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_QWAIT,
        ST_APPLY
    } state_t;

endpackage

// ----- rtl/multiset_min_pair_xor.sv -----
// ============================================================================
// multiset_min_pair_xor
// Sorted multiset held in a chain of cells; insert, remove one copy, or
// report the smallest xor of two stored values.
// ============================================================================
// Insert, remove and undefined actions: the cells compare against the accepted
// value in the compare state, then the commit state shifts and loads the result.
// Query: the commit also waits out the registered min tree over the
// neighbor xors before the result is loaded.
// One transaction at a time: a new one is taken only while idle, and the
// commit waits while an unread result is held. Reset clears valid bits.
module multiset_min_pair_xor #(
    parameter int CAPACITY = mmpx_pkg::DEF_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mmpx_pkg::cmd_item_t cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output mmpx_pkg::res_item_t res
);

    localparam int LEVELS = $clog2(CAPACITY);

    mmpx_pkg::cell_ctrl_t         cell_ctrl;
    mmpx_pkg::cell_link_t         link     [CAPACITY];
    mmpx_pkg::cell_link_t         prev_l   [CAPACITY];
    mmpx_pkg::cell_link_t         next_l   [CAPACITY];
    logic [mmpx_pkg::VALUE_W-1:0] pair_xor [CAPACITY];
    logic [CAPACITY-1:0]          match_vec;
    logic                         any_match;
    logic [mmpx_pkg::VALUE_W-1:0] tree_min;

    // chain of cells with neighbor links
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign prev_l[k] = '{valid: 1'b1, gt: 1'b0, value: '0};
            end
            else
            begin : g_mid
                assign prev_l[k] = link[k-1];
            end
            if (k == CAPACITY - 1)
            begin : g_tail
                assign next_l[k] = '{valid: 1'b0, gt: 1'b0, value: '0};
            end
            else
            begin : g_body
                assign next_l[k] = link[k+1];
            end

            mmpx_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .prev_link (prev_l[k]),
                .next_link (next_l[k]),
                .link      (link[k]),
                .match     (match_vec[k]),
                .pair_xor  (pair_xor[k])
            );
        end
    endgenerate

    // value present anywhere in the chain
    assign any_match = |match_vec;

    mmpx_min_tree #(
        .N (CAPACITY),
        .W (mmpx_pkg::VALUE_W)
    ) u_tree (
        .clk     (clk),
        .leaf    (pair_xor),
        .min_out (tree_min)
    );

    mmpx_ctrl #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cell_ctrl (cell_ctrl),
        .any_match (any_match),
        .tree_min  (tree_min)
    );

endmodule

// ----- rtl/mmpx_cell.sv -----
// ============================================================================
// mmpx_cell
// One slot of the sorted chain: holds a value and a valid bit, compares it
// against the broadcast value, shifts in from a neighbor on insert or remove
// and keeps the xor with its right neighbor for the query tree.
// ============================================================================
module mmpx_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmpx_pkg::cell_ctrl_t         ctrl,
    input  mmpx_pkg::cell_link_t         prev_link,
    input  mmpx_pkg::cell_link_t         next_link,
    output mmpx_pkg::cell_link_t         link,
    output logic                         match,
    output logic [mmpx_pkg::VALUE_W-1:0] pair_xor
);

    logic [mmpx_pkg::VALUE_W-1:0] val_reg, val_next;
    logic                         valid_reg, valid_next;
    logic                         gt_reg, ge_reg, eq_reg;
    logic [mmpx_pkg::VALUE_W-1:0] xor_reg;

    // shift control per command
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        unique case (ctrl.cmd)
            mmpx_pkg::CMD_INSERT:
            begin
                if (prev_link.gt)
                    val_next = prev_link.value;
                else if (gt_reg || !valid_reg)
                    val_next = ctrl.value;
                valid_next = valid_reg | prev_link.valid;
            end
            mmpx_pkg::CMD_REMOVE:
            begin
                if (ge_reg)
                    val_next = next_link.value;
                valid_next = next_link.valid;
            end
            default:
            begin
                val_next   = val_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // stored value, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        xor_reg <= (valid_reg && next_link.valid) ? (val_reg ^ next_link.value)
                                                  : '1;
    end

    // valid bit and compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            gt_reg    <= valid_reg && (val_reg >  ctrl.value);
            ge_reg    <= valid_reg && (val_reg >= ctrl.value);
            eq_reg    <= valid_reg && (val_reg == ctrl.value);
        end
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt_reg;
    assign link.value = val_reg;
    assign match      = eq_reg;
    assign pair_xor   = xor_reg;

endmodule

// ----- rtl/mmpx_min_tree.sv -----
// ============================================================================
// mmpx_min_tree
// Registered binary minimum tree, one register level per tree level.
// Leaves past the input count read as all ones.
// ============================================================================
module mmpx_min_tree #(
    parameter int N = mmpx_pkg::DEF_CAPACITY,
    parameter int W = mmpx_pkg::VALUE_W
) (
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] min_out
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
    localparam int P      = 1 << LEVELS;

    logic [W-1:0] pad  [P];
    logic [W-1:0] node [1:P-1];

    // leaves, padded
    genvar i;
    generate
        for (i = 0; i < P; i++)
        begin : g_leaf
            if (i < N)
            begin : g_used
                assign pad[i] = leaf[i];
            end
            else
            begin : g_pad
                assign pad[i] = '1;
            end
        end

        // inner nodes, registered
        for (i = 1; i < P; i++)
        begin : g_node
            if (2*i >= P)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node[i] <= (pad[2*i-P] < pad[2*i+1-P]) ? pad[2*i-P] : pad[2*i+1-P];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node[i] <= (node[2*i] < node[2*i+1]) ? node[2*i] : node[2*i+1];
                end
            end
        end
    endgenerate

    assign min_out = node[1];

endmodule

// ----- rtl/mmpx_ctrl.sv -----
// ============================================================================
// mmpx_ctrl
// Sequencer for the sorted chain: takes a transaction, lets the cells compare,
// waits out the min tree for queries, then commits the shift, updates the
// count and loads the result register.
// ============================================================================
module mmpx_ctrl #(
    parameter int CAPACITY = mmpx_pkg::DEF_CAPACITY,
    parameter int LEVELS   = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  mmpx_pkg::cmd_item_t          cmd,
    output logic                         res_valid,
    input  logic                         res_ready,
    output mmpx_pkg::res_item_t          res,
    output mmpx_pkg::cell_ctrl_t         cell_ctrl,
    input  logic                         any_match,
    input  logic [mmpx_pkg::VALUE_W-1:0] tree_min
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    mmpx_pkg::state_t             state_reg, state_next;
    mmpx_pkg::action_t            act_reg;
    logic [mmpx_pkg::VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [WAIT_W-1:0]            wait_reg, wait_next;
    mmpx_pkg::res_item_t          res_reg, res_next;
    logic                         res_valid_reg;
    logic                         fire;
    mmpx_pkg::cell_cmd_t          cmd_sel;
    mmpx_pkg::status_t            status_sel;
    logic [mmpx_pkg::VALUE_W-1:0] min_sel;

    assign fire = (state_reg == mmpx_pkg::ST_APPLY) && (!res_valid_reg || res_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmpx_pkg::ST_IDLE:
                if (cmd_valid)
                    state_next = mmpx_pkg::ST_CMP;
            mmpx_pkg::ST_CMP:
                state_next = (act_reg == mmpx_pkg::ACT_QUERY) ? mmpx_pkg::ST_QWAIT
                                                              : mmpx_pkg::ST_APPLY;
            mmpx_pkg::ST_QWAIT:
                if (wait_reg == '0)
                    state_next = mmpx_pkg::ST_APPLY;
            mmpx_pkg::ST_APPLY:
                if (fire)
                    state_next = mmpx_pkg::ST_IDLE;
            default:
                state_next = mmpx_pkg::ST_IDLE;
        endcase
    end

    // action decode and result
    always_comb
    begin
        cmd_sel    = mmpx_pkg::CMD_HOLD;
        status_sel = mmpx_pkg::STAT_OK;
        min_sel    = '0;
        cnt_next   = cnt_reg;
        unique case (act_reg)
            mmpx_pkg::ACT_INSERT:
            begin
                if (cnt_reg == CNT_W'(CAPACITY))
                    status_sel = mmpx_pkg::STAT_FULL;
                else
                begin
                    cmd_sel  = mmpx_pkg::CMD_INSERT;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            mmpx_pkg::ACT_REMOVE:
            begin
                if (any_match)
                begin
                    cmd_sel  = mmpx_pkg::CMD_REMOVE;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                    status_sel = mmpx_pkg::STAT_ABSENT;
            end
            mmpx_pkg::ACT_QUERY:
            begin
                if (cnt_reg < CNT_W'(2))
                    status_sel = mmpx_pkg::STAT_FEW;
                else
                    min_sel = tree_min;
            end
            default:
            begin
                status_sel = mmpx_pkg::STAT_OK;
            end
        endcase
        res_next.min_xor   = min_sel;
        res_next.status    = status_sel;
        res_next.occupancy = mmpx_pkg::OCC_W'(cnt_next);
    end

    // tree wait counter
    always_comb
    begin
        wait_next = wait_reg;
        if (state_reg == mmpx_pkg::ST_CMP)
            wait_next = WAIT_W'(LEVELS - 1);
        else if (state_reg == mmpx_pkg::ST_QWAIT)
            wait_next = wait_reg - WAIT_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmpx_pkg::ST_IDLE;
            cnt_reg       <= '0;
            wait_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (fire)
            begin
                cnt_reg       <= cnt_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            act_reg <= mmpx_pkg::action_t'(cmd.action);
            val_reg <= cmd.value;
        end
        if (fire)
            res_reg <= res_next;
    end

    // outputs
    always_comb
    begin
        cmd_ready       = (state_reg == mmpx_pkg::ST_IDLE);
        res_valid       = res_valid_reg;
        res             = res_reg;
        cell_ctrl.cmd   = fire ? cmd_sel : mmpx_pkg::CMD_HOLD;
        cell_ctrl.value = val_reg;
    end

endmodule

// ----- bench/multiset_min_pair_xor_test.sv -----
// ============================================================================
// multiset_min_pair_xor_test
// Self-checking bench for the sorted multiset / minimum pair xor block.
// A scoreboard keeps its own sorted copy of the multiset and predicts one
// result per accepted command. It covers insert, remove, query and the unused
// action, the full, absent and too-few cases, and a fill to capacity and a
// drain back to empty. Both sides see random gaps and stalls.
// ============================================================================
module multiset_min_pair_xor_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = mmpx_pkg::DEF_CAPACITY;
    localparam int VALUE_W     = mmpx_pkg::VALUE_W;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;

    // tracks the multiset and the results still owed by the block
    class pair_xor_scoreboard;
        logic [VALUE_W-1:0]  sorted_vals[$];
        mmpx_pkg::res_item_t pending_results[$];
        int                  errors;

        // apply one accepted command and queue its result
        function void note_cmd(mmpx_pkg::cmd_item_t c);
            mmpx_pkg::res_item_t r;
            int                  pos;
            logic [VALUE_W-1:0]  x;
            r = '0;
            case (mmpx_pkg::action_t'(c.action))
            mmpx_pkg::ACT_INSERT:
            begin
                if (sorted_vals.size() >= CAPACITY)
                begin
                    r.status = mmpx_pkg::STAT_FULL;
                end
                else
                begin
                    // new copy goes after existing equal values
                    pos = 0;
                    while (pos < sorted_vals.size() && sorted_vals[pos] <= c.value)
                    begin
                        pos++;
                    end
                    sorted_vals.insert(pos, c.value);
                end
            end
            mmpx_pkg::ACT_REMOVE:
            begin
                pos = 0;
                while (pos < sorted_vals.size() && sorted_vals[pos] != c.value)
                begin
                    pos++;
                end
                if (pos >= sorted_vals.size())
                begin
                    r.status = mmpx_pkg::STAT_ABSENT;
                end
                else
                begin
                    sorted_vals.delete(pos);
                end
            end
            mmpx_pkg::ACT_QUERY:
            begin
                if (sorted_vals.size() < 2)
                begin
                    r.status = mmpx_pkg::STAT_FEW;
                end
                else
                begin
                    // minimum lies between sorted neighbors
                    r.min_xor = sorted_vals[0] ^ sorted_vals[1];
                    for (pos = 2; pos < sorted_vals.size(); pos++)
                    begin
                        x = sorted_vals[pos-1] ^ sorted_vals[pos];
                        if (x < r.min_xor)
                        begin
                            r.min_xor = x;
                        end
                    end
                end
            end
            default:
            begin
            end
            endcase
            r.occupancy = mmpx_pkg::OCC_W'(sorted_vals.size());
            pending_results.push_back(r);
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(mmpx_pkg::res_item_t got);
            mmpx_pkg::res_item_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: min_xor %0h status %0d occupancy %0d",
                       got.min_xor, got.status, got.occupancy);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.min_xor !== want.min_xor)
            begin
                $error("min_xor: expected %0h, got %0h", want.min_xor, got.min_xor);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function logic [VALUE_W-1:0] pick_stored();
            return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        endfunction

        function bit holds(logic [VALUE_W-1:0] v);
            foreach (sorted_vals[i])
            begin
                if (sorted_vals[i] == v)
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    mmpx_pkg::cmd_item_t cmd       = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    mmpx_pkg::res_item_t res;

    pair_xor_scoreboard board = new();

    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    int hold_req    = 0;
    int cycle_count = 0;

    multiset_min_pair_xor #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            board.check_result(res);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // values spread over all bits, with clusters near stored ones
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
        0: v = VALUE_W'($urandom_range(0, 15));
        1: v = ~VALUE_W'($urandom_range(0, 15));
        2: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
        3:
        begin
            if (board.sorted_vals.size() > 0)
            begin
                v = board.pick_stored()
                    ^ (VALUE_W'($urandom_range(0, 1)) << $urandom_range(0, VALUE_W - 1));
            end
            else
            begin
                v = VALUE_W'($urandom());
            end
        end
        default: v = VALUE_W'($urandom());
        endcase
        return v;
    endfunction

    // mostly a stored value, sometimes anything
    function automatic logic [VALUE_W-1:0] remove_value();
        if (board.sorted_vals.size() > 0 && $urandom_range(0, 4) != 0)
        begin
            return board.pick_stored();
        end
        return rand_value();
    endfunction

    function automatic logic [VALUE_W-1:0] absent_value();
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom());
        while (board.holds(v))
        begin
            v = VALUE_W'($urandom());
        end
        return v;
    endfunction

    // drive one command transaction; called at a falling edge
    task automatic issue(input mmpx_pkg::action_t act, input logic [VALUE_W-1:0] v);
        int gap;
        cmd.action = act;
        cmd.value  = v;
        cmd_valid  = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ready);
        board.note_cmd(cmd);
        @(negedge clk);
        gap = (src_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            issue(mmpx_pkg::ACT_INSERT, rand_value());
        end
        else if (pick < 75)
        begin
            issue(mmpx_pkg::ACT_REMOVE, remove_value());
        end
        else if (pick < 95)
        begin
            issue(mmpx_pkg::ACT_QUERY, VALUE_W'($urandom()));
        end
        else
        begin
            issue(mmpx_pkg::ACT_NONE, VALUE_W'($urandom()));
        end
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drain();
        cmd_valid = 1'b0;
        while (board.pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // result sink with random stalls and requested long holds
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                stall = pick_gap();
            end
            else
            begin
                stall = 0;
            end
            res_ready = (stall == 0);
            if (stall > 1)
            begin
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // stimulus
    initial
    begin
        int pick;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty store, extremes, duplicates, unused action
        sink_stalls = 1'b1;
        issue(mmpx_pkg::ACT_QUERY, '0);
        issue(mmpx_pkg::ACT_REMOVE, VALUE_W'(5));
        issue(mmpx_pkg::ACT_INSERT, '0);
        issue(mmpx_pkg::ACT_QUERY, '1);
        issue(mmpx_pkg::ACT_INSERT, '1);
        issue(mmpx_pkg::ACT_QUERY, '0);
        issue(mmpx_pkg::ACT_INSERT, '0);
        issue(mmpx_pkg::ACT_QUERY, '0);
        issue(mmpx_pkg::ACT_NONE, '1);
        issue(mmpx_pkg::ACT_NONE, '0);
        issue(mmpx_pkg::ACT_REMOVE, '0);
        issue(mmpx_pkg::ACT_REMOVE, VALUE_W'(30'h2AAAAAAA));
        issue(mmpx_pkg::ACT_INSERT, VALUE_W'(30'h15555555));
        issue(mmpx_pkg::ACT_INSERT, VALUE_W'(30'h2AAAAAAA));
        issue(mmpx_pkg::ACT_QUERY, '1);
        issue(mmpx_pkg::ACT_REMOVE, '1);
        issue(mmpx_pkg::ACT_REMOVE, '0);
        issue(mmpx_pkg::ACT_REMOVE, VALUE_W'(30'h15555555));
        issue(mmpx_pkg::ACT_QUERY, '0);
        issue(mmpx_pkg::ACT_REMOVE, VALUE_W'(30'h2AAAAAAA));
        issue(mmpx_pkg::ACT_INSERT, VALUE_W'(1));
        issue(mmpx_pkg::ACT_INSERT, VALUE_W'(2));
        issue(mmpx_pkg::ACT_INSERT, VALUE_W'(3));
        issue(mmpx_pkg::ACT_QUERY, '0);

        // random mix with idling on both sides
        src_gaps = 1'b1;
        repeat (40) random_item();

        // sink holds off long while commands keep coming
        src_gaps = 1'b0;
        hold_req = LONG_HOLD;
        repeat (8) random_item();
        wait_drain();

        // fill to capacity with no idling
        sink_stalls = 1'b0;
        while (board.sorted_vals.size() < CAPACITY)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 95)
            begin
                issue(mmpx_pkg::ACT_INSERT, rand_value());
            end
            else if (pick < 98)
            begin
                issue(mmpx_pkg::ACT_QUERY, VALUE_W'($urandom()));
            end
            else
            begin
                issue(mmpx_pkg::ACT_REMOVE, remove_value());
            end
        end

        // full store
        issue(mmpx_pkg::ACT_INSERT, rand_value());
        issue(mmpx_pkg::ACT_INSERT, board.pick_stored());
        issue(mmpx_pkg::ACT_INSERT, '0);
        issue(mmpx_pkg::ACT_INSERT, '1);
        issue(mmpx_pkg::ACT_QUERY, VALUE_W'($urandom()));
        issue(mmpx_pkg::ACT_REMOVE, absent_value());
        issue(mmpx_pkg::ACT_NONE, VALUE_W'($urandom()));
        issue(mmpx_pkg::ACT_REMOVE, board.pick_stored());
        issue(mmpx_pkg::ACT_INSERT, rand_value());
        issue(mmpx_pkg::ACT_INSERT, rand_value());

        // drain to empty with idling
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        while (board.sorted_vals.size() > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 95)
            begin
                issue(mmpx_pkg::ACT_REMOVE, board.pick_stored());
            end
            else if (pick < 97)
            begin
                issue(mmpx_pkg::ACT_REMOVE, rand_value());
            end
            else if (pick < 99)
            begin
                issue(mmpx_pkg::ACT_QUERY, VALUE_W'($urandom()));
            end
            else
            begin
                issue(mmpx_pkg::ACT_NONE, VALUE_W'($urandom()));
            end
        end
        issue(mmpx_pkg::ACT_QUERY, '1);
        issue(mmpx_pkg::ACT_INSERT, rand_value());
        issue(mmpx_pkg::ACT_QUERY, '0);

        // source pauses until everything is back
        wait_drain();
        @(negedge clk);

        // closing random mix
        repeat (20) random_item();

        // let the block settle, then report
        wait_drain();
        repeat (30) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
